@@ hw/rtl/felq_pkg.sv @@
package felq_pkg;

  localparam int unsigned TIMER_WIDTH = 24;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned EVENT_WIDTH = 32;
  localparam int unsigned APB_DATA_WIDTH = 32;
  localparam int unsigned APB_ADDR_WIDTH = 4;
  localparam int unsigned IN_TDATA_WIDTH = 8;
  localparam int unsigned OUT_TDATA_WIDTH = 40;

  localparam logic [TIMER_WIDTH-1:0] RISE_LOCKOUT_RESET = TIMER_WIDTH'(2000);
  localparam logic [TIMER_WIDTH-1:0] FALL_LOCKOUT_RESET = TIMER_WIDTH'(10000);
  localparam logic [TIMER_WIDTH-1:0] FRAME_PULSE_RESET  = TIMER_WIDTH'(8000);
  localparam logic [TIMER_WIDTH-1:0] EOF_PULSE_RESET    = TIMER_WIDTH'(1000000);

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_RISE_LOCKOUT = 2'd0,
    REG_FALL_LOCKOUT = 2'd1,
    REG_FRAME_PULSE  = 2'd2,
    REG_EOF_PULSE    = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    PH_ARM_RISE  = 6'b000001,
    PH_ARM_FALL  = 6'b000010,
    PH_LOCK_RISE = 6'b000100,
    PH_LOCK_FALL = 6'b001000,
    PH_HALTED    = 6'b010000,
    PH_UNARMED   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [TIMER_WIDTH-1:0] rise_lockout_ticks;
    logic [TIMER_WIDTH-1:0] fall_lockout_ticks;
    logic [TIMER_WIDTH-1:0] frame_pulse_ticks;
    logic [TIMER_WIDTH-1:0] eof_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   restart_level;
    logic                   film_end_level;
    logic                   frame_level;
  } levels_t;

  // packed so that frame_pulse is bit 0
  typedef struct packed {
    logic [EVENT_WIDTH-1:0] event_count;
    logic                   film_end_strobe;
    logic                   frame_strobe;
    logic                   motor_stop;
    logic                   film_end_pulse;
    logic                   frame_pulse;
  } result_t;

endpackage

@@ hw/rtl/felq_cfg_regs.sv @@
module felq_cfg_regs (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [felq_pkg::APB_ADDR_WIDTH-1:0]     paddr,
  input  logic [felq_pkg::APB_DATA_WIDTH-1:0]     pwdata,
  output logic [felq_pkg::APB_DATA_WIDTH-1:0]     prdata,
  output logic                                    pready,
  output felq_pkg::cfg_t                          cfg_o
);

  felq_pkg::cfg_t   cfg_q;
  felq_pkg::reg_idx_e idx;
  logic             wr_en;
  logic [felq_pkg::TIMER_WIDTH-1:0] wval;
  logic [felq_pkg::TIMER_WIDTH-1:0] rval;

  assign pready = 1'b1;
  assign idx    = felq_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign wval   = pwdata[felq_pkg::TIMER_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_lockout_ticks <= felq_pkg::RISE_LOCKOUT_RESET;
      cfg_q.fall_lockout_ticks <= felq_pkg::FALL_LOCKOUT_RESET;
      cfg_q.frame_pulse_ticks  <= felq_pkg::FRAME_PULSE_RESET;
      cfg_q.eof_pulse_ticks    <= felq_pkg::EOF_PULSE_RESET;
    end else if (wr_en) begin
      case (idx)
        felq_pkg::REG_RISE_LOCKOUT: cfg_q.rise_lockout_ticks <= wval;
        felq_pkg::REG_FALL_LOCKOUT: cfg_q.fall_lockout_ticks <= wval;
        felq_pkg::REG_FRAME_PULSE:  cfg_q.frame_pulse_ticks  <= wval;
        felq_pkg::REG_EOF_PULSE:    cfg_q.eof_pulse_ticks    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      felq_pkg::REG_RISE_LOCKOUT: rval = cfg_q.rise_lockout_ticks;
      felq_pkg::REG_FALL_LOCKOUT: rval = cfg_q.fall_lockout_ticks;
      felq_pkg::REG_FRAME_PULSE:  rval = cfg_q.frame_pulse_ticks;
      felq_pkg::REG_EOF_PULSE:    rval = cfg_q.eof_pulse_ticks;
      default:                    rval = '0;
    endcase
  end

  assign prdata = felq_pkg::APB_DATA_WIDTH'(rval);
  assign cfg_o  = cfg_q;

endmodule

@@ hw/rtl/felq_core.sv @@
module felq_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  felq_pkg::cfg_t    cfg_i,
  input  logic              fire_i,
  input  felq_pkg::levels_t levels_i,
  output felq_pkg::result_t result_o
);

  localparam int unsigned TW = felq_pkg::TIMER_WIDTH;
  localparam int unsigned CW = felq_pkg::COUNT_WIDTH;

  felq_pkg::levels_t prev_q;
  felq_pkg::phase_e  phase_q, phase_d;
  logic [TW-1:0]     lock_q, lock_d;
  logic [TW-1:0]     fp_q, fp_d;
  logic [TW-1:0]     ep_q, ep_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              armed_q, armed_d;
  logic              motor_q, motor_d;

  logic              f_rise, f_fall, e_rise, r_fall;
  logic              frame_ok, fstrobe, estrobe;
  logic [CW-1:0]     count_out;

  assign f_rise = !prev_q.frame_level && levels_i.frame_level;
  assign f_fall = prev_q.frame_level && !levels_i.frame_level;
  assign e_rise = !prev_q.film_end_level && levels_i.film_end_level;
  assign r_fall = prev_q.restart_level && !levels_i.restart_level;

  always_comb begin
    phase_d   = phase_q;
    lock_d    = lock_q;
    fp_d      = (fp_q != '0) ? fp_q - TW'(1) : fp_q;
    ep_d      = (ep_q != '0) ? ep_q - TW'(1) : ep_q;
    cnt_d     = cnt_q;
    armed_d   = armed_q;
    motor_d   = motor_q;
    frame_ok  = 1'b1;
    fstrobe   = 1'b0;
    estrobe   = 1'b0;
    count_out = '0;

    if (phase_q == felq_pkg::PH_LOCK_RISE || phase_q == felq_pkg::PH_LOCK_FALL) begin
      if (lock_q != '0) begin
        lock_d   = lock_q - TW'(1);
        frame_ok = 1'b0;
      end else begin
        phase_d = (phase_q == felq_pkg::PH_LOCK_RISE) ? felq_pkg::PH_ARM_FALL
                                                       : felq_pkg::PH_ARM_RISE;
      end
    end

    if (e_rise && armed_q) begin
      estrobe   = 1'b1;
      count_out = cnt_q;
      ep_d      = cfg_i.eof_pulse_ticks;
      motor_d   = 1'b1;
      cnt_d     = '0;
      armed_d   = 1'b0;
      phase_d   = felq_pkg::PH_HALTED;
      lock_d    = '0;
      frame_ok  = 1'b0;
    end

    // restart overrides a halt taken on the same tick
    if (r_fall) begin
      cnt_d    = '0;
      lock_d   = '0;
      phase_d  = levels_i.frame_level ? felq_pkg::PH_ARM_FALL : felq_pkg::PH_ARM_RISE;
      frame_ok = 1'b0;
    end

    if (frame_ok) begin
      case (phase_d)
        felq_pkg::PH_ARM_RISE: begin
          if (f_rise) begin
            phase_d = felq_pkg::PH_LOCK_RISE;
            lock_d  = cfg_i.rise_lockout_ticks;
          end
        end
        felq_pkg::PH_ARM_FALL: begin
          if (f_fall) begin
            fstrobe   = 1'b1;
            count_out = cnt_q;
            if (cnt_q == '0) armed_d = 1'b1;
            fp_d      = cfg_i.frame_pulse_ticks;
            cnt_d     = cnt_q + CW'(1);
            phase_d   = felq_pkg::PH_LOCK_FALL;
            lock_d    = cfg_i.fall_lockout_ticks;
          end
        end
        felq_pkg::PH_HALTED: ;
        // only the unarmed phase gets here: arm from the current level
        default: begin
          phase_d = levels_i.frame_level ? felq_pkg::PH_ARM_FALL : felq_pkg::PH_ARM_RISE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      phase_q <= felq_pkg::PH_UNARMED;
      lock_q  <= '0;
      fp_q    <= '0;
      ep_q    <= '0;
      cnt_q   <= '0;
      armed_q <= 1'b0;
      motor_q <= 1'b0;
    end else if (fire_i) begin
      prev_q  <= levels_i;
      phase_q <= phase_d;
      lock_q  <= lock_d;
      fp_q    <= fp_d;
      ep_q    <= ep_d;
      cnt_q   <= cnt_d;
      armed_q <= armed_d;
      motor_q <= motor_d;
    end
  end

  assign result_o.frame_pulse     = (fp_d != '0);
  assign result_o.film_end_pulse  = (ep_d != '0);
  assign result_o.motor_stop      = motor_d;
  assign result_o.frame_strobe    = fstrobe;
  assign result_o.film_end_strobe = estrobe;
  assign result_o.event_count     = felq_pkg::EVENT_WIDTH'(count_out);

  a_lock_only_in_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lock_q != '0) |-> (phase_q == felq_pkg::PH_LOCK_RISE ||
                        phase_q == felq_pkg::PH_LOCK_FALL))
    else $error("lockout count running outside a lockout phase");

  a_halt_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == felq_pkg::PH_HALTED) |-> !armed_q)
    else $error("end-of-film detection armed while halted");

  a_eof_stops_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && estrobe) |=> (motor_q && cnt_q == '0))
    else $error("end of film did not latch motor stop and clear count");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && r_fall) |=> (cnt_q == '0 && lock_q == '0))
    else $error("restart did not clear count and lockout");

endmodule

@@ hw/rtl/felq_out_stage.sv @@
module felq_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  felq_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output felq_pkg::result_t out_data_o
);

  logic              main_valid_q;
  logic              skid_valid_q;
  felq_pkg::result_t main_q;
  felq_pkg::result_t skid_q;
  logic              in_fire;
  logic              main_free;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign main_free  = !main_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_free) begin
      if (skid_valid_q) begin
        main_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_free) begin
      main_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word held with empty output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q))
    else $error("skid word not moved to output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !out_ready_i && in_fire) |=> skid_valid_q)
    else $error("word taken during stall was dropped");

endmodule

@@ hw/rtl/frame_edge_lockout_qualifier.sv @@
// Frame edge qualifier with lockout for a film transport sensor.
// Slave stream: one word per microsecond tick with the sampled levels of the
// frame-advance, end-of-film and restart inputs. Master stream: exactly one
// result word per input word, in order: pulse levels, motor stop, strobes and
// the event count.
// A result is computed from its accepted input word and registered in the output
// register, or in the skid buffer while the receiver stalls. Throughput: one word per cycle while s_axis_tready is
// high; the qualifier state updates in a single pass between the accepted word and the output register.
// The output register is backed by a one-word skid buffer, so a word is
// still accepted in the cycle the receiver stalls; s_axis_tready drops only
// when both are full, and nothing is lost or repeated.
// Reset clears the edge history, timers, count, motor stop and end detection
// and sets the phase to unarmed; the timing registers return to 2000, 10000,
// 8000 and 1000000 ticks. The APB port holds the four timing registers at
// byte addresses 0, 4, 8 and 12; write them only while the stream is idle.
module frame_edge_lockout_qualifier (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [felq_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [felq_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [felq_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                   pready,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [0] frame_level, [1] film_end_level, [2] restart_level, [7:3] zero
  input  logic [felq_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [0] frame_pulse, [1] film_end_pulse, [2] motor_stop, [3] frame_strobe,
  // [4] film_end_strobe, [36:5] event_count, [39:37] zero
  output logic [felq_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata
);

  felq_pkg::cfg_t    cfg;
  felq_pkg::levels_t levels;
  felq_pkg::result_t result;
  felq_pkg::result_t out_word;
  logic              in_fire;

  assign levels  = s_axis_tdata[2:0];
  assign in_fire = s_axis_tvalid && s_axis_tready;

  felq_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  felq_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (in_fire),
    .levels_i (levels),
    .result_o (result)
  );

  felq_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (result),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_word)
  );

  assign m_axis_tdata = felq_pkg::OUT_TDATA_WIDTH'(out_word);

endmodule

@@ test/frame_edge_lockout_qualifier_tb.sv @@
`timescale 1ns / 100ps

module frame_edge_lockout_qualifier_tb;
  import felq_pkg::*;

  localparam int unsigned RUN_LIMIT = 300_000;
  localparam int unsigned MAX_TICKS = 16_777_215;

  // Tracks the qualifier state tick by tick and holds the result words still owed.
  class frame_gate_scoreboard;
    logic [TIMER_WIDTH-1:0] rise_len, fall_len, pulse_len, eof_len;
    levels_t                last_lv;
    phase_e                 ph;
    logic [TIMER_WIDTH-1:0] lock_left, pulse_left, eof_left;
    logic [COUNT_WIDTH-1:0] frame_total;
    logic                   end_armed, motor_stopped;
    result_t                owed_words[$];
    int                     errors, words_checked, frames_seen, film_ends_seen;

    function void clear();
      rise_len      = RISE_LOCKOUT_RESET;
      fall_len      = FALL_LOCKOUT_RESET;
      pulse_len     = FRAME_PULSE_RESET;
      eof_len       = EOF_PULSE_RESET;
      last_lv       = '0;
      ph            = PH_UNARMED;
      lock_left     = '0;
      pulse_left    = '0;
      eof_left      = '0;
      frame_total   = '0;
      end_armed     = 1'b0;
      motor_stopped = 1'b0;
      owed_words.delete();
    endfunction

    function void set_timing(reg_idx_e idx, logic [TIMER_WIDTH-1:0] val);
      case (idx)
        REG_RISE_LOCKOUT: rise_len = val;
        REG_FALL_LOCKOUT: fall_len = val;
        REG_FRAME_PULSE:  pulse_len = val;
        REG_EOF_PULSE:    eof_len = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    function void take_levels(levels_t lv);
      logic    f_rise, f_fall, e_rise, r_fall, frame_ok;
      result_t w;
      f_rise   = !last_lv.frame_level && lv.frame_level;
      f_fall   = last_lv.frame_level && !lv.frame_level;
      e_rise   = !last_lv.film_end_level && lv.film_end_level;
      r_fall   = last_lv.restart_level && !lv.restart_level;
      frame_ok = 1'b1;
      w        = '0;

      if (pulse_left != 0) pulse_left = pulse_left - 1'b1;
      if (eof_left != 0) eof_left = eof_left - 1'b1;

      if (ph == PH_LOCK_RISE || ph == PH_LOCK_FALL) begin
        if (lock_left != 0) begin
          lock_left = lock_left - 1'b1;
          frame_ok  = 1'b0;
        end else begin
          ph = (ph == PH_LOCK_RISE) ? PH_ARM_FALL : PH_ARM_RISE;
        end
      end

      // end of film wins over frame edges, even inside a lockout; a restart still wins
      if (e_rise && end_armed) begin
        w.film_end_strobe = 1'b1;
        w.event_count     = frame_total;
        eof_left          = eof_len;
        motor_stopped     = 1'b1;
        frame_total       = '0;
        end_armed         = 1'b0;
        ph                = PH_HALTED;
        lock_left         = '0;
        frame_ok          = 1'b0;
        film_ends_seen++;
      end

      if (r_fall) begin
        frame_total = '0;
        lock_left   = '0;
        ph          = lv.frame_level ? PH_ARM_FALL : PH_ARM_RISE;
        frame_ok    = 1'b0;
      end

      if (frame_ok) begin
        case (ph)
          PH_ARM_RISE: begin
            if (f_rise) begin
              ph        = PH_LOCK_RISE;
              lock_left = rise_len;
            end
          end
          PH_ARM_FALL: begin
            if (f_fall) begin
              w.frame_strobe = 1'b1;
              w.event_count  = frame_total;
              if (frame_total == 0) end_armed = 1'b1;
              pulse_left     = pulse_len;
              frame_total    = frame_total + 1'b1;
              ph             = PH_LOCK_FALL;
              lock_left      = fall_len;
              frames_seen++;
            end
          end
          PH_HALTED: ;
          default: ph = lv.frame_level ? PH_ARM_FALL : PH_ARM_RISE;
        endcase
      end

      last_lv          = lv;
      w.frame_pulse    = (pulse_left != 0);
      w.film_end_pulse = (eof_left != 0);
      w.motor_stop     = motor_stopped;
      owed_words.push_back(w);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      compare_field("frame_pulse", want.frame_pulse, got.frame_pulse);
      compare_field("film_end_pulse", want.film_end_pulse, got.film_end_pulse);
      compare_field("motor_stop", want.motor_stop, got.motor_stop);
      compare_field("frame_strobe", want.frame_strobe, got.frame_strobe);
      compare_field("film_end_strobe", want.film_end_strobe, got.film_end_strobe);
      compare_field("event_count", want.event_count, got.event_count);
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       psel, penable, pwrite;
  logic [APB_ADDR_WIDTH-1:0]  paddr;
  logic [APB_DATA_WIDTH-1:0]  pwdata;
  logic [APB_DATA_WIDTH-1:0]  prdata;
  logic                       pready;
  logic                       s_axis_tvalid, s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata;
  logic                       m_axis_tvalid, m_axis_tready;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  frame_gate_scoreboard board;
  levels_t              lv_now;
  int                   frame_hold;
  int                   words_taken;
  int                   settings_used;
  int unsigned          cycle_count;
  bit                   tx_burst, rx_burst, long_hold_done;

  frame_edge_lockout_qualifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, board.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_levels(input levels_t lv);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_WIDTH - 3){1'b0}}, lv};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.take_levels(lv);
  endtask

  // stop offering words and let every owed result come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [TIMER_WIDTH-1:0] val);
    logic [APB_DATA_WIDTH-1:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_WIDTH'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.set_timing(idx, val);
    // read back through a fresh setup/access pair
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== APB_DATA_WIDTH'(val)) begin
      $display("%0t: readback of %s mismatch, expected %0h, actual %0h",
               $time, idx.name(), val, rd);
      board.errors++;
    end
  endtask

  task automatic set_timing(input int unsigned rise, input int unsigned fall,
                            input int unsigned pulse, input int unsigned eof);
    drain();
    apb_write(REG_RISE_LOCKOUT, rise[TIMER_WIDTH-1:0]);
    apb_write(REG_FALL_LOCKOUT, fall[TIMER_WIDTH-1:0]);
    apb_write(REG_FRAME_PULSE, pulse[TIMER_WIDTH-1:0]);
    apb_write(REG_EOF_PULSE, eof[TIMER_WIDTH-1:0]);
    settings_used++;
  endtask

  // frame level mostly held for random runs of up to hold_max + 1 ticks, with
  // sparse film-end and restart toggles; one tick in ten is pure noise
  task automatic run_random(input int count, input int hold_max);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        lv_now = levels_t'($urandom_range(0, 7));
      end else begin
        if (frame_hold == 0) begin
          lv_now.frame_level = !lv_now.frame_level;
          frame_hold = $urandom_range(1, hold_max);
        end else begin
          frame_hold--;
        end
        if ($urandom_range(0, 49) == 0) lv_now.film_end_level = !lv_now.film_end_level;
        if ($urandom_range(0, 24) == 0) lv_now.restart_level = !lv_now.restart_level;
      end
      send_levels(lv_now);
    end
  endtask

  // result side, with its own random stalls and one long hold-off
  initial begin : receiver
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 15);
      if (words_taken == 400 && !long_hold_done) begin
        gap = 64;
        long_hold_done = 1'b1;
      end
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      board.check_word(result_t'(m_axis_tdata[EVENT_WIDTH+4:0]));
      words_taken++;
    end
  end

  initial begin : stimulus
    // {restart, film_end, frame} per tick, run under the reset timing
    levels_t directed[26] = '{
      3'b001,  // first tick, frame high: arms for a fall
      3'b000,  // frame 0 counted, film-end detection armed
      3'b001,  // inside fall lockout
      3'b101,
      3'b001,  // restart falls with frame high
      3'b000,  // counted again from zero
      3'b001,
      3'b011,  // film end: strobe, motor stop, halt
      3'b000,  // halted
      3'b001,
      3'b101,
      3'b000,  // restart fall and frame fall together, frame edge dropped
      3'b001,  // rise starts rise lockout
      3'b111,  // film end while not armed
      3'b011,  // restart re-arms for a fall
      3'b010,  // counted, arms film end
      3'b110,
      3'b100,
      3'b110,  // film end inside fall lockout
      3'b101,  // halted, frame rise ignored
      3'b001,
      3'b000,  // counted, armed again
      3'b100,
      3'b010,  // film end and restart fall on the same tick
      3'b011,  // restart overrode the halt
      3'b000
    };

    board = new();
    board.clear();
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    lv_now        = '0;
    frame_hold    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_levels(directed[i]);
    lv_now = directed[25];

    set_timing(1, 1, 1, 1);
    run_random(150, 4);

    repeat (3) begin
      set_timing($urandom_range(1, 8), $urandom_range(1, 8),
                 $urandom_range(1, 8), $urandom_range(1, 8));
      run_random(150, 12);
    end

    set_timing(MAX_TICKS, MAX_TICKS, MAX_TICKS, MAX_TICKS);
    run_random(60, 6);

    set_timing(MAX_TICKS, 1, MAX_TICKS, 1);
    run_random(60, 6);

    // frame pulses longer than the lockouts so retriggers land mid-pulse
    set_timing($urandom_range(1, 3), $urandom_range(2, 5),
               $urandom_range(6, 20), $urandom_range(3, 30));
    run_random(130, 8);

    drain();
    repeat (5) @(posedge clk_i);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, board.pending());
      board.errors++;
    end

    $display("Checked %0d result words across %0d timing settings plus reset values.",
             board.words_checked, settings_used);
    $display("Saw %0d counted frames and %0d film-end events, %0d errors.",
             board.frames_seen, board.film_ends_seen, board.errors);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
